// ----- rtl/core/csrs_pkg.sv -----
package csrs_pkg;

    localparam int SCORE_IO_W = 32;
    localparam int INDEX_IO_W = 4;

    typedef enum logic [2:0] {
        S_LOAD,
        S_HOLD,
        S_SCAN,
        S_STORE,
        S_EMIT_RD,
        S_EMIT_LD
    } state_t;

endpackage

// ----- rtl/core/csrs_if.sv -----
interface csrs_score_if;
    import csrs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [SCORE_IO_W-1:0] score;

    modport source (output valid, output score, input ready);
    modport sink   (input valid, input score, output ready);
endinterface

interface csrs_rank_if;
    import csrs_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [INDEX_IO_W-1:0] class_index;
    logic [SCORE_IO_W-1:0] ranked_score;
    logic                  last_rank;

    modport source (output valid, output class_index, output ranked_score,
                    output last_rank, input ready);
    modport sink   (input valid, input class_index, input ranked_score,
                    input last_rank, output ready);
endinterface

// ----- rtl/core/class_score_ranking_sort_unit.sv -----
// Ranks a run of NUM_SCORES classifier scores, highest first. Scores are taken one per
// item and numbered 0..NUM_SCORES-1 in arrival order; one item is accepted per cycle
// while loading. After the last score of a run, the block stops taking items and runs an
// exchange sort over one RAM (score and index kept together) with a single comparator:
// entry i is held in a register and compared against entries i+1..N-1 in turn, one per
// cycle, swapping on strictly greater. Results then leave one at a time, each read from the
// RAM in S_EMIT_RD and loaded in S_EMIT_LD once the output register is free (sink ready
// or register empty), class_index masked to 4 bits, last_rank set on the final one;
// loading of the next run starts as soon as the last result is in the output register.
// Scores are compared as signed SCORE_WIDTH-bit values taken from the low input bits.
module class_score_ranking_sort_unit #(
    parameter int NUM_SCORES  = 10,
    parameter int SCORE_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    csrs_score_if.sink         scores,
    csrs_rank_if.source        ranks
);
    import csrs_pkg::*;

    localparam int IDX_W  = $clog2(NUM_SCORES);
    localparam int WORD_W = SCORE_WIDTH + IDX_W;

    state_t state_reg, state_next;
    logic [IDX_W-1:0] load_cnt_reg, load_cnt_next;
    logic [IDX_W-1:0] i_reg, i_next;
    logic [IDX_W-1:0] j_reg, j_next;
    logic [WORD_W-1:0] held_reg, held_next;

    logic                  out_valid_reg, out_valid_next;
    logic [INDEX_IO_W-1:0] out_index_reg, out_index_next;
    logic [SCORE_IO_W-1:0] out_score_reg, out_score_next;
    logic                  out_last_reg, out_last_next;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic [IDX_W-1:0]  ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic [SCORE_WIDTH-1:0] in_score;
    logic [SCORE_WIDTH-1:0] rd_score;
    logic [IDX_W-1:0]       rd_index;
    logic [SCORE_WIDTH-1:0] held_score;
    logic                   swap;
    logic                   out_free;

    csrs_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_SCORES)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_score   = SCORE_WIDTH'($signed(scores.score));
    assign rd_score   = ram_rdata[WORD_W-1:IDX_W];
    assign rd_index   = ram_rdata[IDX_W-1:0];
    assign held_score = held_reg[WORD_W-1:IDX_W];
    assign swap       = $signed(rd_score) > $signed(held_score);
    assign out_free   = !out_valid_reg || ranks.ready;

    assign scores.ready       = (state_reg == S_LOAD);
    assign ranks.valid        = out_valid_reg;
    assign ranks.class_index  = out_index_reg;
    assign ranks.ranked_score = out_score_reg;
    assign ranks.last_rank    = out_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            load_cnt_reg  <= '0;
            i_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            load_cnt_reg  <= load_cnt_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_reg      <= held_next;
        out_index_reg <= out_index_next;
        out_score_reg <= out_score_next;
        out_last_reg  <= out_last_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        load_cnt_next  = load_cnt_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        held_next      = held_reg;
        out_valid_next = out_valid_reg;
        out_index_next = out_index_reg;
        out_score_next = out_score_reg;
        out_last_next  = out_last_reg;
        ram_we         = 1'b0;
        ram_waddr      = load_cnt_reg;
        ram_wdata      = {in_score, load_cnt_reg};
        ram_raddr      = '0;

        if (out_valid_reg && ranks.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_LOAD:
            begin
                // entry 0 is read here so it is ready when the sort starts
                if (scores.valid)
                begin
                    ram_we = 1'b1;
                    if (load_cnt_reg == IDX_W'(NUM_SCORES - 1))
                    begin
                        load_cnt_next = '0;
                        i_next        = '0;
                        state_next    = S_HOLD;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + 1'b1;
                    end
                end
            end
            S_HOLD:
            begin
                held_next  = ram_rdata;
                ram_raddr  = i_reg + 1'b1;
                j_next     = i_reg + 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // rdata is entry j; entry j+1 is fetched in the same cycle
                if (swap)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = j_reg;
                    ram_wdata = held_reg;
                    held_next = ram_rdata;
                end
                if (j_reg == IDX_W'(NUM_SCORES - 1))
                begin
                    state_next = S_STORE;
                end
                else
                begin
                    ram_raddr = j_reg + 1'b1;
                    j_next    = j_reg + 1'b1;
                end
            end
            S_STORE:
            begin
                ram_we    = 1'b1;
                ram_waddr = i_reg;
                ram_wdata = held_reg;
                ram_raddr = i_reg + 1'b1;
                if (i_reg == IDX_W'(NUM_SCORES - 2))
                begin
                    i_next     = '0;
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_HOLD;
                end
            end
            S_EMIT_RD:
            begin
                ram_raddr  = i_reg;
                state_next = S_EMIT_LD;
            end
            S_EMIT_LD:
            begin
                ram_raddr = i_reg;
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = INDEX_IO_W'(rd_index);
                    out_score_next = SCORE_IO_W'($signed(rd_score));
                    out_last_next  = (i_reg == IDX_W'(NUM_SCORES - 1));
                    if (i_reg == IDX_W'(NUM_SCORES - 1))
                    begin
                        i_next     = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_EMIT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // a finished run is followed by a fresh load, never a stray result
    assert property (@(posedge clk) disable iff (!rst_n)
        (ranks.valid && ranks.ready && ranks.last_rank) |=> !ranks.valid)
        else $error("result after last rank without a new run");

    assert property (@(posedge clk) disable iff (!rst_n)
        load_cnt_reg <= IDX_W'(NUM_SCORES - 1))
        else $error("load count past end of run");

    // swap write and look-ahead read must never hit the same entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN && ram_we) |-> (ram_waddr != ram_raddr))
        else $error("scan write collides with read");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (j_reg > i_reg))
        else $error("scan index not above held entry");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_LD && !out_free) |=> $stable(i_reg))
        else $error("rank index moved while output stalled");
endmodule

// ----- rtl/core/csrs_ram.sv -----
module csrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule

// ----- tb/class_score_ranking_checker.sv -----
`timescale 1ns / 1ps

module class_score_ranking_checker #(
    parameter int NUM_SCORES  = 10,
    parameter int SCORE_WIDTH = 32
) (
    input  logic   clk,
    input  logic   rst_n,
    csrs_score_if  scores,
    csrs_rank_if   ranks,
    output int     fail_count,
    output int     ranks_pending
);
    import csrs_pkg::*;

    typedef struct packed {
        logic [INDEX_IO_W-1:0] class_index;
        logic [SCORE_IO_W-1:0] ranked_score;
        logic                  last_rank;
    } rank_t;

    rank_t pending_ranks[$];
    rank_t want;

    logic signed [SCORE_WIDTH-1:0] run_scores[NUM_SCORES];
    int                            run_index[NUM_SCORES];
    int                            loaded;

    // Exchange sort, descending; ties keep whatever order the swaps leave.
    function automatic void rank_run();
        logic signed [SCORE_WIDTH-1:0] held_score;
        int                            held_index;
        rank_t                         r;
        for (int i = 0; i < NUM_SCORES; i++)
        begin
            for (int j = i; j < NUM_SCORES; j++)
            begin
                if (run_scores[j] > run_scores[i])
                begin
                    held_score    = run_scores[i];
                    held_index    = run_index[i];
                    run_scores[i] = run_scores[j];
                    run_index[i]  = run_index[j];
                    run_scores[j] = held_score;
                    run_index[j]  = held_index;
                end
            end
        end
        for (int k = 0; k < NUM_SCORES; k++)
        begin
            r.class_index  = INDEX_IO_W'(run_index[k]);
            r.ranked_score = SCORE_IO_W'(run_scores[k]);
            r.last_rank    = (k == NUM_SCORES - 1);
            pending_ranks.push_back(r);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loaded = 0;
            pending_ranks.delete();
            fail_count = 0;
        end
        else
        begin
            if (ranks.valid && ranks.ready)
            begin
                if (pending_ranks.size() == 0)
                begin
                    $error("unexpected item: class_index %0d ranked_score %0h last_rank %0b",
                           ranks.class_index, ranks.ranked_score, ranks.last_rank);
                    fail_count++;
                end
                else
                begin
                    want = pending_ranks.pop_front();
                    if (ranks.class_index !== want.class_index)
                    begin
                        $error("class_index: expected %0d, got %0d",
                               want.class_index, ranks.class_index);
                        fail_count++;
                    end
                    if (ranks.ranked_score !== want.ranked_score)
                    begin
                        $error("ranked_score: expected %0h, got %0h",
                               want.ranked_score, ranks.ranked_score);
                        fail_count++;
                    end
                    if (ranks.last_rank !== want.last_rank)
                    begin
                        $error("last_rank: expected %0b, got %0b",
                               want.last_rank, ranks.last_rank);
                        fail_count++;
                    end
                end
            end
            if (scores.valid && scores.ready)
            begin
                run_scores[loaded] = SCORE_WIDTH'($signed(scores.score));
                run_index[loaded]  = loaded;
                loaded++;
                if (loaded == NUM_SCORES)
                begin
                    loaded = 0;
                    rank_run();
                end
            end
        end
        ranks_pending = pending_ranks.size();
    end

endmodule

// ----- tb/tb_class_score_ranking_sort_unit.sv -----
`timescale 1ns / 1ps

module tb_class_score_ranking_sort_unit;
    import csrs_pkg::*;

    localparam int NUM_SCORES   = 10;
    localparam int SCORE_WIDTH  = 32;
    localparam int RANDOM_RUNS  = 31;
    localparam int SINK_HOLD    = 300;
    localparam int STALL_LIMIT  = 3000;
    localparam int DRAIN_CYCLES = 150;

    logic clk;
    logic rst_n;
    bit   hold_sink;
    int   idle_cycles;
    int   check_fails;
    int   ranks_pending;

    csrs_score_if scores_ch();
    csrs_rank_if  ranks_ch();

    class_score_ranking_sort_unit #(
        .NUM_SCORES  (NUM_SCORES),
        .SCORE_WIDTH (SCORE_WIDTH)
    ) DUT (
        .clk    (clk),
        .rst_n  (rst_n),
        .scores (scores_ch),
        .ranks  (ranks_ch)
    );

    class_score_ranking_checker #(
        .NUM_SCORES  (NUM_SCORES),
        .SCORE_WIDTH (SCORE_WIDTH)
    ) score_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .scores        (scores_ch),
        .ranks         (ranks_ch),
        .fail_count    (check_fails),
        .ranks_pending (ranks_pending)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Mostly back-to-back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Called and returns at a falling edge.
    task automatic send_score(input logic [SCORE_IO_W-1:0] value, input int gap);
        if (gap > 0)
        begin
            scores_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        scores_ch.valid <= 1'b1;
        scores_ch.score <= value;
        do
            @(posedge clk);
        while (!scores_ch.ready);
        @(negedge clk);
    endtask

    task automatic send_run(input logic [SCORE_IO_W-1:0] run[NUM_SCORES], input bit steady);
        for (int k = 0; k < NUM_SCORES; k++)
            send_score(run[k], steady ? 0 : pick_gap());
    endtask

    task automatic send_random_run();
        logic [SCORE_IO_W-1:0] run[NUM_SCORES];
        logic [SCORE_IO_W-1:0] base;
        logic [SCORE_IO_W-1:0] step;
        int                    flavor;
        flavor = $urandom_range(0, 9);
        base   = $urandom;
        step   = $urandom_range(1, 1000);
        for (int k = 0; k < NUM_SCORES; k++)
        begin
            case (flavor)
                5, 6:    run[k] = SCORE_IO_W'($urandom_range(0, 4) - 2);   // heavy ties
                7:
                begin
                    case ($urandom_range(0, 4))
                        0:       run[k] = 32'h7FFF_FFFF;
                        1:       run[k] = 32'h8000_0000;
                        2:       run[k] = '0;
                        3:       run[k] = '1;
                        default: run[k] = $urandom;
                    endcase
                end
                8:       run[k] = base;                                     // all equal
                9:       run[k] = base + k * step;                          // ascending, may wrap
                default: run[k] = $urandom;
            endcase
        end
        send_run(run, $urandom_range(0, 3) == 0);
    endtask

    // Sink side: random bursts and lulls, plus one long hold-off on request.
    initial
    begin
        int burst;
        int lull;
        burst = 0;
        lull  = 0;
        ranks_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (hold_sink)
            begin
                ranks_ch.ready <= 1'b0;
                repeat (SINK_HOLD) @(negedge clk);
                hold_sink = 1'b0;
            end
            else if (burst > 0)
            begin
                ranks_ch.ready <= 1'b1;
                burst--;
            end
            else if (lull > 0)
            begin
                ranks_ch.ready <= 1'b0;
                lull--;
            end
            else
            begin
                ranks_ch.ready <= 1'b1;
                burst = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
                lull  = pick_gap() + 1;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((scores_ch.valid && scores_ch.ready) || (ranks_ch.valid && ranks_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [SCORE_IO_W-1:0] extremes_run[NUM_SCORES];
        logic [SCORE_IO_W-1:0] ties_run[NUM_SCORES];
        extremes_run = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'hFFFF_FFFF, 32'h1,
                         32'h8000_0001, 32'h7FFF_FFFE, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0};
        ties_run     = '{32'd5, 32'd5, -32'sd3, 32'd5, -32'sd3,
                         32'd7, 32'd7, 32'd0, 32'd0, 32'd5};
        hold_sink       = 1'b0;
        idle_cycles     = 0;
        scores_ch.valid = 1'b0;
        scores_ch.score = '0;
        rst_n           = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_run(extremes_run, 1'b1);
        send_run(ties_run, 1'b0);

        // sink stalls while scores keep coming, so the block fills and blocks input
        hold_sink = 1'b1;
        for (int run = 0; run < RANDOM_RUNS; run++)
        begin
            if (run == RANDOM_RUNS / 2)
            begin
                // sender goes quiet until every pending result has come out
                scores_ch.valid <= 1'b0;
                wait (ranks_pending == 0);
                @(negedge clk);
            end
            send_random_run();
        end
        scores_ch.valid <= 1'b0;

        wait (ranks_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (check_fails == 0 && ranks_pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- class_score_ranking_sort_unit.f -----
rtl/core/csrs_pkg.sv
rtl/core/csrs_if.sv
rtl/core/csrs_ram.sv
rtl/core/class_score_ranking_sort_unit.sv
tb/class_score_ranking_checker.sv
tb/tb_class_score_ranking_sort_unit.sv
